>>> rtl/fwp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwp_pkg : shared types and constants of the flow layout placer
// Register indexes, mode bit positions, fixed field widths and the flag group
// that travels with an item from the placement stage to the result stage.
// ----------------------------------------------------------------------------
package fwp_pkg;

    typedef enum logic [2:0] {
        REG_AREA_LEFT   = 3'd0,
        REG_AREA_TOP    = 3'd1,
        REG_AREA_RIGHT  = 3'd2,
        REG_AREA_BOTTOM = 3'd3,
        REG_H_SPACING   = 3'd4,
        REG_V_SPACING   = 3'd5,
        REG_MODE        = 3'd6,
        REG_EXTENT_PAD  = 3'd7
    } t_reg_idx;

    localparam int REG_IDX_BITS = 3;

    // mode register bits
    localparam int MODE_VERT = 0;
    localparam int MODE_RTL  = 1;

    localparam int SPACING_BITS = 10;
    localparam int MODE_BITS    = 2;
    localparam int PAD_BITS     = 12;

    localparam int RST_AREA_RIGHT  = 1023;
    localparam int RST_AREA_BOTTOM = 1023;

    typedef struct packed {
        logic placed;
        logic wrapped;
        logic last;
    } t_flags;

endpackage
`default_nettype wire

>>> rtl/flow_layout_wrap_placer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flow_layout_wrap_placer : greedy flow layout with line wrap
// Places a stream of boxes into rows or columns of a configured area.
// ----------------------------------------------------------------------------
// Boxes enter on a valid/stall channel and one result leaves for every box,
// in order. While the output is not stalled the block takes one box every
// cycle: the only feedback path is the placement stage, which reads pen,
// line thickness and maximum extent and writes their new values in the
// same cycle, so consecutive boxes never wait
// on each other. The pipe is an input register, the placement stage and the
// result register that also works out the running extents; each stage holds
// its item while the one after it is full and stalled, so the input keeps
// taking boxes until all three are occupied. A box flagged last ends the list
// and the following box starts again from the area corner, using the area and
// mode registers as they are at that moment. Write configuration only while
// the pipe is empty; writes take effect on the next box. Hidden boxes are
// reported with placed low, corner zero and the unchanged extents. There is no
// memory and no clearing pass after reset.
// ----------------------------------------------------------------------------
module flow_layout_wrap_placer #(
    parameter int COORD_BITS = 16
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // configuration
    input  wire                                    i_cfg_we,
    input  wire  [fwp_pkg::REG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire  [((COORD_BITS > fwp_pkg::PAD_BITS) ? COORD_BITS
                   : fwp_pkg::PAD_BITS)-1:0]       i_cfg_data,
    // box items
    input  wire                                    i_valid,
    output logic                                   o_stall,
    input  wire  [COORD_BITS-2:0]                  i_box_width,
    input  wire  [COORD_BITS-2:0]                  i_box_height,
    input  wire                                    i_box_empty,
    input  wire                                    i_last_box,
    // result items
    output logic                                   o_valid,
    input  wire                                    i_stall,
    output logic signed [COORD_BITS-1:0]           o_pos_x,
    output logic signed [COORD_BITS-1:0]           o_pos_y,
    output logic                                   o_placed,
    output logic                                   o_wrapped,
    output logic [COORD_BITS-2:0]                  o_extent_w,
    output logic [COORD_BITS-2:0]                  o_extent_h,
    output logic                                   o_end_of_list
);
    import fwp_pkg::*;

    // configuration
    logic signed [COORD_BITS-1:0] area_left, area_top, area_right, area_bottom;
    logic [SPACING_BITS-1:0]      h_spacing, v_spacing;
    logic [MODE_BITS-1:0]         mode;
    logic [PAD_BITS-1:0]          extent_pad;

    // pipe control
    logic r_a_valid, r_b_valid, r_c_valid;
    logic a_free, b_free, c_free, b_load, c_load;

    // input register
    logic [COORD_BITS-2:0] r_a_width, r_a_height;
    logic                  r_a_empty, r_a_last;

    // placement stage outputs
    logic signed [COORD_BITS+1:0] pen_x, pen_y;
    logic [COORD_BITS-2:0]        line_thk;
    logic [COORD_BITS:0]          max_ext;
    logic signed [COORD_BITS+2:0] b_pos_x, b_pos_y;
    t_flags                       b_flags, c_flags;

    fwp_regs #(.COORD_BITS(COORD_BITS)) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_area_left   (area_left),
        .o_area_top    (area_top),
        .o_area_right  (area_right),
        .o_area_bottom (area_bottom),
        .o_h_spacing   (h_spacing),
        .o_v_spacing   (v_spacing),
        .o_mode        (mode),
        .o_extent_pad  (extent_pad)
    );

    // a stage is free when empty or when its item moves on this cycle
    assign c_free  = !r_c_valid || !i_stall;
    assign b_free  = !r_b_valid || c_free;
    assign a_free  = !r_a_valid || b_free;
    assign b_load  = r_a_valid && b_free;
    assign c_load  = r_b_valid && c_free;
    assign o_stall = !a_free;
    assign o_valid = r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // capture the box on acceptance, hold it while the pipe is stalled
    always_ff @(posedge i_clk) begin
        if (a_free && i_valid) begin
            r_a_width  <= i_box_width;
            r_a_height <= i_box_height;
            r_a_empty  <= i_box_empty;
            r_a_last   <= i_last_box;
        end
    end

    fwp_place #(.COORD_BITS(COORD_BITS)) u_place (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (b_load),
        .i_box_width   (r_a_width),
        .i_box_height  (r_a_height),
        .i_box_empty   (r_a_empty),
        .i_last_box    (r_a_last),
        .i_area_left   (area_left),
        .i_area_top    (area_top),
        .i_area_right  (area_right),
        .i_area_bottom (area_bottom),
        .i_h_spacing   (h_spacing),
        .i_v_spacing   (v_spacing),
        .i_mode        (mode),
        .o_pen_x       (pen_x),
        .o_pen_y       (pen_y),
        .o_line_thk    (line_thk),
        .o_max_ext     (max_ext),
        .o_pos_x       (b_pos_x),
        .o_pos_y       (b_pos_y),
        .o_flags       (b_flags)
    );

    // the state registers hold the post-placement state of the item in the
    // placement stage until that item moves on
    fwp_extent #(.COORD_BITS(COORD_BITS)) u_extent (
        .i_clk         (i_clk),
        .i_load        (c_load),
        .i_pen_x       (pen_x),
        .i_pen_y       (pen_y),
        .i_line_thk    (line_thk),
        .i_max_ext     (max_ext),
        .i_pos_x       (b_pos_x),
        .i_pos_y       (b_pos_y),
        .i_flags       (b_flags),
        .i_area_left   (area_left),
        .i_area_top    (area_top),
        .i_area_right  (area_right),
        .i_mode        (mode),
        .i_extent_pad  (extent_pad),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_extent_w    (o_extent_w),
        .o_extent_h    (o_extent_h),
        .o_flags       (c_flags)
    );

    assign o_placed      = c_flags.placed;
    assign o_wrapped     = c_flags.wrapped;
    assign o_end_of_list = c_flags.last;

    // a hidden box reports a zero corner and no wrap
    a_skip_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_placed |-> o_pos_x == '0 && o_pos_y == '0 && !o_wrapped)
        else $error("skipped box carries a corner or a wrap");

    // an item reaches the placement stage only from the input register
    a_b_from_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_b_valid) |-> $past(r_a_valid))
        else $error("placement stage filled without an input item");

endmodule
`default_nettype wire

>>> rtl/fwp_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwp_regs : configuration register file
// Eight write-only registers, loaded by index from the configuration port.
// ----------------------------------------------------------------------------
module fwp_regs #(
    parameter int COORD_BITS = 16
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire  [fwp_pkg::REG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire  [((COORD_BITS > fwp_pkg::PAD_BITS) ? COORD_BITS
                   : fwp_pkg::PAD_BITS)-1:0]       i_cfg_data,
    output logic signed [COORD_BITS-1:0]           o_area_left,
    output logic signed [COORD_BITS-1:0]           o_area_top,
    output logic signed [COORD_BITS-1:0]           o_area_right,
    output logic signed [COORD_BITS-1:0]           o_area_bottom,
    output logic [fwp_pkg::SPACING_BITS-1:0]       o_h_spacing,
    output logic [fwp_pkg::SPACING_BITS-1:0]       o_v_spacing,
    output logic [fwp_pkg::MODE_BITS-1:0]          o_mode,
    output logic [fwp_pkg::PAD_BITS-1:0]           o_extent_pad
);
    import fwp_pkg::*;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_area_left   <= '0;
            o_area_top    <= '0;
            o_area_right  <= COORD_BITS'(RST_AREA_RIGHT);
            o_area_bottom <= COORD_BITS'(RST_AREA_BOTTOM);
            o_h_spacing   <= '0;
            o_v_spacing   <= '0;
            o_mode        <= '0;
            o_extent_pad  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_AREA_LEFT:   o_area_left   <= i_cfg_data[COORD_BITS-1:0];
                REG_AREA_TOP:    o_area_top    <= i_cfg_data[COORD_BITS-1:0];
                REG_AREA_RIGHT:  o_area_right  <= i_cfg_data[COORD_BITS-1:0];
                REG_AREA_BOTTOM: o_area_bottom <= i_cfg_data[COORD_BITS-1:0];
                REG_H_SPACING:   o_h_spacing   <= i_cfg_data[SPACING_BITS-1:0];
                REG_V_SPACING:   o_v_spacing   <= i_cfg_data[SPACING_BITS-1:0];
                REG_MODE:        o_mode        <= i_cfg_data[MODE_BITS-1:0];
                REG_EXTENT_PAD:  o_extent_pad  <= i_cfg_data[PAD_BITS-1:0];
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/fwp_place.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwp_place : placement stage
// Holds pen, line thickness and maximum extent; places one box per load and
// registers its corner and flags.
// ----------------------------------------------------------------------------
module fwp_place #(
    parameter int COORD_BITS = 16
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_load,
    input  wire  [COORD_BITS-2:0]                  i_box_width,
    input  wire  [COORD_BITS-2:0]                  i_box_height,
    input  wire                                    i_box_empty,
    input  wire                                    i_last_box,
    input  wire  signed [COORD_BITS-1:0]           i_area_left,
    input  wire  signed [COORD_BITS-1:0]           i_area_top,
    input  wire  signed [COORD_BITS-1:0]           i_area_right,
    input  wire  signed [COORD_BITS-1:0]           i_area_bottom,
    input  wire  [fwp_pkg::SPACING_BITS-1:0]       i_h_spacing,
    input  wire  [fwp_pkg::SPACING_BITS-1:0]       i_v_spacing,
    input  wire  [fwp_pkg::MODE_BITS-1:0]          i_mode,
    output logic signed [COORD_BITS+1:0]           o_pen_x,
    output logic signed [COORD_BITS+1:0]           o_pen_y,
    output logic [COORD_BITS-2:0]                  o_line_thk,
    output logic [COORD_BITS:0]                    o_max_ext,
    output logic signed [COORD_BITS+2:0]           o_pos_x,
    output logic signed [COORD_BITS+2:0]           o_pos_y,
    output fwp_pkg::t_flags                        o_flags
);
    import fwp_pkg::*;

    localparam int ST_W = COORD_BITS + 2;
    localparam int SZ_W = COORD_BITS - 1;
    localparam int CW   = ((ST_W > PAD_BITS + 1) ? ST_W : PAD_BITS + 1) + 3;

    localparam logic signed [CW-1:0] ST_MAX = {{(CW-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
    localparam logic signed [CW-1:0] ST_MIN = {{(CW-ST_W+1){1'b1}}, {(ST_W-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE    = {{(CW-1){1'b0}}, 1'b1};
    localparam logic signed [CW-1:0] ZERO   = '0;

    logic r_start;

    function automatic logic signed [CW-1:0] sat_st(input logic signed [CW-1:0] v);
        if (v > ST_MAX) begin
            return ST_MAX;
        end else if (v < ST_MIN) begin
            return ST_MIN;
        end
        return v;
    endfunction

    logic                 vert, rtl;
    logic signed [CW-1:0] l, t, r, b, hs, vs, w, h;
    logic signed [CW-1:0] x0, y0, lt0, me0;
    logic signed [CW-1:0] x, y, ltw, ext, mx;
    logic signed [CW-1:0] n_px, n_py, n_pen_x, n_pen_y, n_lt, n_me;
    logic                 over, wrap;

    always_comb begin
        vert = i_mode[MODE_VERT];
        rtl  = i_mode[MODE_RTL];
        l    = CW'(i_area_left);
        t    = CW'(i_area_top);
        r    = CW'(i_area_right);
        b    = CW'(i_area_bottom);
        hs   = signed'({{(CW-SPACING_BITS){1'b0}}, i_h_spacing});
        vs   = signed'({{(CW-SPACING_BITS){1'b0}}, i_v_spacing});
        w    = signed'({{(CW-SZ_W){1'b0}}, i_box_width});
        h    = signed'({{(CW-SZ_W){1'b0}}, i_box_height});

        // a new list starts from the area corner as configured now
        x0  = r_start ? (rtl ? r : l) : CW'(o_pen_x);
        y0  = r_start ? t : CW'(o_pen_y);
        lt0 = r_start ? ZERO : signed'({{(CW-SZ_W){1'b0}}, o_line_thk});
        me0 = r_start ? ZERO : signed'({{(CW-ST_W+1){1'b0}}, o_max_ext});

        if (!vert) begin
            over    = rtl ? (x0 - w + ONE < l) : (x0 + w - ONE > r);
            wrap    = over && (lt0 != ZERO);
            x       = wrap ? (rtl ? r : l) : x0;
            y       = wrap ? sat_st(y0 + lt0 + vs) : y0;
            ltw     = wrap ? ZERO : lt0;
            n_px    = rtl ? (x - w + ONE) : x;
            n_py    = y;
            ext     = rtl ? (r - x + w) : (x + w - l);
            n_pen_x = sat_st(rtl ? (x - w - hs + ONE) : (x + w + hs - ONE));
            n_pen_y = y;
            n_lt    = (h > ltw) ? h : ltw;
        end else begin
            over    = (y0 + h - ONE > b);
            wrap    = over && (lt0 != ZERO);
            y       = wrap ? t : y0;
            x       = wrap ? sat_st(rtl ? (x0 - lt0 - hs) : (x0 + lt0 + hs)) : x0;
            ltw     = wrap ? ZERO : lt0;
            n_px    = rtl ? (x - w) : x;
            n_py    = y;
            ext     = y + h - t;
            n_pen_x = x;
            n_pen_y = sat_st(y + h + vs - ONE);
            n_lt    = (w > ltw) ? w : ltw;
        end

        mx   = (ext > me0) ? ext : me0;
        n_me = (mx < ZERO) ? ZERO : ((mx > ST_MAX) ? ST_MAX : mx);

        // hidden box: report only, keep the state
        if (i_box_empty) begin
            wrap    = 1'b0;
            n_px    = ZERO;
            n_py    = ZERO;
            n_pen_x = x0;
            n_pen_y = y0;
            n_lt    = lt0;
            n_me    = me0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
        end else if (i_load) begin
            r_start <= i_last_box;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_pen_x         <= n_pen_x[ST_W-1:0];
            o_pen_y         <= n_pen_y[ST_W-1:0];
            o_line_thk      <= n_lt[SZ_W-1:0];
            o_max_ext       <= n_me[ST_W-2:0];
            o_pos_x         <= n_px[ST_W:0];
            o_pos_y         <= n_py[ST_W:0];
            o_flags.placed  <= !i_box_empty;
            o_flags.wrapped <= wrap;
            o_flags.last    <= i_last_box;
        end
    end

    // first box of a list never reports a wrap
    a_first_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && r_start |=> !o_flags.wrapped)
        else $error("first box of a list reported a wrap");

    // maximum extent only grows within a list
    a_ext_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && !r_start |=> o_max_ext >= $past(o_max_ext))
        else $error("maximum extent shrank within a list");

endmodule
`default_nettype wire

>>> rtl/fwp_extent.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwp_extent : result stage
// Works out the running layout extent from the updated state and saturates
// corner and extents into the result register.
// ----------------------------------------------------------------------------
module fwp_extent #(
    parameter int COORD_BITS = 16
) (
    input  wire                                    i_clk,
    input  wire                                    i_load,
    input  wire  signed [COORD_BITS+1:0]           i_pen_x,
    input  wire  signed [COORD_BITS+1:0]           i_pen_y,
    input  wire  [COORD_BITS-2:0]                  i_line_thk,
    input  wire  [COORD_BITS:0]                    i_max_ext,
    input  wire  signed [COORD_BITS+2:0]           i_pos_x,
    input  wire  signed [COORD_BITS+2:0]           i_pos_y,
    input  fwp_pkg::t_flags                        i_flags,
    input  wire  signed [COORD_BITS-1:0]           i_area_left,
    input  wire  signed [COORD_BITS-1:0]           i_area_top,
    input  wire  signed [COORD_BITS-1:0]           i_area_right,
    input  wire  [fwp_pkg::MODE_BITS-1:0]          i_mode,
    input  wire  [fwp_pkg::PAD_BITS-1:0]           i_extent_pad,
    output logic signed [COORD_BITS-1:0]           o_pos_x,
    output logic signed [COORD_BITS-1:0]           o_pos_y,
    output logic [COORD_BITS-2:0]                  o_extent_w,
    output logic [COORD_BITS-2:0]                  o_extent_h,
    output fwp_pkg::t_flags                        o_flags
);
    import fwp_pkg::*;

    localparam int ST_W = COORD_BITS + 2;
    localparam int SZ_W = COORD_BITS - 1;
    localparam int CW   = ((ST_W > PAD_BITS + 1) ? ST_W : PAD_BITS + 1) + 3;

    localparam logic signed [CW-1:0] CO_MAX = {{(CW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [CW-1:0] CO_MIN = {{(CW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE    = {{(CW-1){1'b0}}, 1'b1};
    localparam logic signed [CW-1:0] ZERO   = '0;

    function automatic logic [SZ_W-1:0] clamp_sz(input logic signed [CW-1:0] v);
        if (v < ZERO) begin
            return '0;
        end else if (v > CO_MAX) begin
            return CO_MAX[SZ_W-1:0];
        end
        return v[SZ_W-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_co(input logic signed [CW-1:0] v);
        if (v > CO_MAX) begin
            return CO_MAX[COORD_BITS-1:0];
        end else if (v < CO_MIN) begin
            return CO_MIN[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    logic signed [CW-1:0] px, py, lt, me, pad, ew, eh;

    always_comb begin
        px  = CW'(i_pen_x);
        py  = CW'(i_pen_y);
        lt  = signed'({{(CW-SZ_W){1'b0}}, i_line_thk});
        me  = signed'({{(CW-ST_W+1){1'b0}}, i_max_ext});
        pad = signed'({{(CW-PAD_BITS){1'b0}}, i_extent_pad});
        if (!i_mode[MODE_VERT]) begin
            ew = me;
            eh = py + lt - CW'(i_area_top) + pad;
        end else begin
            ew = i_mode[MODE_RTL] ? (CW'(i_area_right) - px + lt + ONE + pad)
                                  : (px + lt - CW'(i_area_left) + pad);
            eh = me;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_pos_x    <= clamp_co(CW'(i_pos_x));
            o_pos_y    <= clamp_co(CW'(i_pos_y));
            o_extent_w <= clamp_sz(ew);
            o_extent_h <= clamp_sz(eh);
            o_flags    <= i_flags;
        end
    end

endmodule
`default_nettype wire

>>> test/flow_layout_wrap_placer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_layout_wrap_placer_tb : self-checking bench for the flow layout placer
// Drives boxes through the valid/stall channel and checks every result item
// against an in-bench placement predictor. A directed table covers the reset
// state, extremes, saturation, all four flow modes, hidden boxes, mid-list
// register writes and an inverted area. Random phases with fresh settings
// follow, under sender bursts, receiver stall patterns and one long hold-off.
// ----------------------------------------------------------------------------
module flow_layout_wrap_placer_tb;
    import fwp_pkg::*;

    localparam int  CB             = 16;             // coordinate width
    localparam int  SB             = CB - 1;         // size width
    localparam int  CFG_W          = 16;             // widest register
    localparam longint ST_MAX      = (64'sd1 <<< (CB + 1)) - 1;
    localparam longint ST_MIN      = -(64'sd1 <<< (CB + 1));
    localparam longint CO_MAX      = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint CO_MIN      = -(64'sd1 <<< (CB - 1));
    localparam longint SZ_MAX      = (64'sd1 <<< SB) - 1;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  PIPE_LATENCY   = 8;
    localparam int  PHASES         = 25;
    localparam int  PHASE_ITEMS    = 50;
    localparam int  DIR_ROWS       = 45;

    typedef struct packed {
        logic signed [CB-1:0] pos_x;
        logic signed [CB-1:0] pos_y;
        logic                 placed;
        logic                 wrapped;
        logic [SB-1:0]        extent_w;
        logic [SB-1:0]        extent_h;
        logic                 end_of_list;
    } placement_t;

    typedef enum bit { ROW_BOX, ROW_CFG } row_kind_e;

    // one row of the directed table: either a register write or a box,
    // with the result typed in where it is obvious
    typedef struct {
        row_kind_e  kind;
        t_reg_idx   idx;
        int         data;
        int         w;
        int         h;
        bit         empty;
        bit         last;
        bit         typed;
        placement_t want;
    } dir_row_t;

    localparam placement_t NO_RESULT = '0;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [REG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [SB-1:0]           i_box_width;
    logic [SB-1:0]           i_box_height;
    logic                    i_box_empty;
    logic                    i_last_box;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [CB-1:0]    o_pos_x;
    logic signed [CB-1:0]    o_pos_y;
    logic                    o_placed;
    logic                    o_wrapped;
    logic [SB-1:0]           o_extent_w;
    logic [SB-1:0]           o_extent_h;
    logic                    o_end_of_list;

    flow_layout_wrap_placer #(
        .COORD_BITS (CB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .i_box_empty   (i_box_empty),
        .i_last_box    (i_last_box),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_placed      (o_placed),
        .o_wrapped     (o_wrapped),
        .o_extent_w    (o_extent_w),
        .o_extent_h    (o_extent_h),
        .o_end_of_list (o_end_of_list)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow registers and placement state of the predictor
    // ------------------------------------------------------------------------
    logic signed [CB-1:0]        area_l, area_t, area_r, area_b;
    logic [SPACING_BITS-1:0]     gap_h, gap_v;
    logic [MODE_BITS-1:0]        flow_mode;
    logic [PAD_BITS-1:0]         pad_sum;

    longint pen_x, pen_y, line_th, max_ext;
    bit     list_start;

    placement_t placement_q [$];
    int         errors       = 0;
    int         stuck_cycles = 0;
    int         burst_left   = 0;
    bit         hold_req     = 1'b0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Work out the result of one box and advance the placement state.
    function automatic placement_t predict_placement(longint w, longint h,
                                                     bit empty, bit last);
        longint     lft, top, rgt, bot, hs, vs, pad;
        longint     x, y, px, py, ext, ew, eh;
        bit         vert, rtl;
        placement_t r;
        lft  = longint'(area_l);
        top  = longint'(area_t);
        rgt  = longint'(area_r);
        bot  = longint'(area_b);
        hs   = longint'(gap_h);
        vs   = longint'(gap_v);
        pad  = longint'(pad_sum);
        vert = flow_mode[MODE_VERT];
        rtl  = flow_mode[MODE_RTL];
        px   = 0;
        py   = 0;
        ext  = 0;
        r    = '0;

        // a new list picks up the corner from the registers as they are now
        if (list_start) begin
            pen_x      = rtl ? rgt : lft;
            pen_y      = top;
            line_th    = 0;
            max_ext    = 0;
            list_start = 1'b0;
        end

        if (!empty) begin
            x        = pen_x;
            y        = pen_y;
            r.placed = 1'b1;
            if (!vert) begin
                // rows: wrap only when the line already holds something
                if ((rtl ? (x - w + 1 < lft) : (x + w - 1 > rgt)) && line_th > 0) begin
                    x         = rtl ? rgt : lft;
                    y         = clamp(y + line_th + vs, ST_MIN, ST_MAX);
                    line_th   = 0;
                    r.wrapped = 1'b1;
                end
                py = y;
                if (rtl) begin
                    px    = x - w + 1;
                    ext   = rgt - x + w;
                    pen_x = clamp(x - w - hs + 1, ST_MIN, ST_MAX);
                end else begin
                    px    = x;
                    ext   = x + w - lft;
                    pen_x = clamp(x + w + hs - 1, ST_MIN, ST_MAX);
                end
                pen_y = y;
                if (h > line_th) line_th = h;
            end else begin
                // columns: step sideways by the column thickness on wrap
                if (y + h - 1 > bot && line_th > 0) begin
                    y         = top;
                    x         = rtl ? x - line_th - hs : x + line_th + hs;
                    x         = clamp(x, ST_MIN, ST_MAX);
                    line_th   = 0;
                    r.wrapped = 1'b1;
                end
                px    = rtl ? x - w : x;
                py    = y;
                ext   = y + h - top;
                pen_x = x;
                pen_y = clamp(y + h + vs - 1, ST_MIN, ST_MAX);
                if (w > line_th) line_th = w;
            end
            if (ext > max_ext) max_ext = ext;
            max_ext = clamp(max_ext, 0, ST_MAX);
        end

        if (!vert) begin
            ew = max_ext;
            eh = pen_y + line_th - top + pad;
        end else begin
            ew = rtl ? (rgt - pen_x + line_th + 1 + pad) : (pen_x + line_th - lft + pad);
            eh = max_ext;
        end

        r.pos_x       = CB'(clamp(px, CO_MIN, CO_MAX));
        r.pos_y       = CB'(clamp(py, CO_MIN, CO_MAX));
        r.extent_w    = SB'(clamp(ew, 0, SZ_MAX));
        r.extent_h    = SB'(clamp(eh, 0, SZ_MAX));
        r.end_of_list = last;
        if (last) list_start = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Leave the enable high; the next box lowers it, so a run of writes never
    // drops and raises it within one step.
    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_AREA_LEFT:   area_l    = data;
            REG_AREA_TOP:    area_t    = data;
            REG_AREA_RIGHT:  area_r    = data;
            REG_AREA_BOTTOM: area_b    = data;
            REG_H_SPACING:   gap_h     = data[SPACING_BITS-1:0];
            REG_V_SPACING:   gap_v     = data[SPACING_BITS-1:0];
            REG_MODE:        flow_mode = data[MODE_BITS-1:0];
            REG_EXTENT_PAD:  pad_sum   = data[PAD_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected item is out and the pipe is
    // certainly empty.
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (placement_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    // Offer one box, honouring the burst/gap pattern, and queue its result
    // once accepted.
    task automatic send_box(int w, int h, bit empty, bit last, bit typed,
                            placement_t want);
        placement_t got;
        int         gap;
        gap      = 0;
        i_cfg_we <= 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_box_width  <= SB'(w);
        i_box_height <= SB'(h);
        i_box_empty  <= empty;
        i_last_box   <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        got = predict_placement(w, h, empty, last);
        placement_q.push_back(typed ? want : got);
    endtask

    // ------------------------------------------------------------------------
    // Directed table: reset defaults first, so the opening rows carry their
    // results typed in (saturation of pos_y and of both extents included).
    // ------------------------------------------------------------------------
    dir_row_t directed_rows [DIR_ROWS] = '{
        // reset area 0..1023, row flow left to right
        '{ROW_BOX, REG_AREA_LEFT, 0, 100, 50, 1'b0, 1'b0, 1'b1,
          '{16'sd0, 16'sd0, 1'b1, 1'b0, 15'd100, 15'd50, 1'b0}},
        // hidden box: no move, current extents
        '{ROW_BOX, REG_AREA_LEFT, 0, 5, 5, 1'b1, 1'b0, 1'b1,
          '{16'sd0, 16'sd0, 1'b0, 1'b0, 15'd100, 15'd50, 1'b0}},
        // largest box wraps, extents saturate
        '{ROW_BOX, REG_AREA_LEFT, 0, 32767, 32767, 1'b0, 1'b0, 1'b1,
          '{16'sd0, 16'sd50, 1'b1, 1'b1, 15'd32767, 15'd32767, 1'b0}},
        // zero box wraps again, pos_y saturates
        '{ROW_BOX, REG_AREA_LEFT, 0, 0, 0, 1'b0, 1'b1, 1'b1,
          '{16'sd0, 16'sd32767, 1'b1, 1'b1, 15'd32767, 15'd32767, 1'b1}},
        // fresh list from the corner, first box never flagged as wrapped
        '{ROW_BOX, REG_AREA_LEFT, 0, 0, 0, 1'b0, 1'b0, 1'b1,
          '{16'sd0, 16'sd0, 1'b1, 1'b0, 15'd0, 15'd0, 1'b0}},
        // oversized box on an empty line stays on it
        '{ROW_BOX, REG_AREA_LEFT, 0, 2000, 10, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 21845, 10922, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 10922, 21845, 1'b0, 1'b1, 1'b0, NO_RESULT},
        // rows right to left, widest gaps and pad
        '{ROW_CFG, REG_MODE, 2, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_H_SPACING, 1023, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_V_SPACING, 1023, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_EXTENT_PAD, 4095, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 300, 40, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 400, 60, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 500, 20, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 7, 7, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 1, 1, 1'b0, 1'b1, 1'b0, NO_RESULT},
        // columns left to right over the widest area
        '{ROW_CFG, REG_MODE, 1, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_LEFT, -32768, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_TOP, -32768, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_RIGHT, 32767, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_BOTTOM, 32767, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_H_SPACING, 0, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_V_SPACING, 0, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_EXTENT_PAD, 0, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 50, 32767, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 60, 32767, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 70, 100, 1'b0, 1'b1, 1'b0, NO_RESULT},
        // columns right to left in a short area
        '{ROW_CFG, REG_MODE, 3, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_LEFT, 0, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_TOP, 0, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_RIGHT, 1023, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_BOTTOM, 500, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 100, 300, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 100, 300, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 20, 20, 1'b0, 1'b1, 1'b0, NO_RESULT},
        // mode and area changed in the middle of a list
        '{ROW_BOX, REG_AREA_LEFT, 0, 30, 30, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_MODE, 0, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 40, 40, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_LEFT, 200, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 2000, 5, 1'b0, 1'b1, 1'b0, NO_RESULT},
        // inverted area
        '{ROW_CFG, REG_AREA_LEFT, 500, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_AREA_RIGHT, 100, 0, 0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 10, 10, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BOX, REG_AREA_LEFT, 0, 10, 10, 1'b0, 1'b1, 1'b0, NO_RESULT}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int          phase, n, k, w, h;
        int unsigned pick;
        bit          in_cfg;
        logic [CFG_W-1:0] settings [8];

        // every input known from time zero, reset held low before release
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_AREA_LEFT;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_box_width  <= '0;
        i_box_height <= '0;
        i_box_empty  <= 1'b0;
        i_last_box   <= 1'b0;

        area_l     = '0;
        area_t     = '0;
        area_r     = CB'(RST_AREA_RIGHT);
        area_b     = CB'(RST_AREA_BOTTOM);
        gap_h      = '0;
        gap_v      = '0;
        flow_mode  = '0;
        pad_sum    = '0;
        pen_x      = 0;
        pen_y      = 0;
        line_th    = 0;
        max_ext    = 0;
        list_start = 1'b1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table; drain before the first write of a group
        in_cfg = 1'b0;
        for (n = 0; n < DIR_ROWS; n++) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                if (!in_cfg) drain_pipe();
                in_cfg = 1'b1;
                write_reg(directed_rows[n].idx, CFG_W'(directed_rows[n].data));
            end else begin
                in_cfg = 1'b0;
                send_box(directed_rows[n].w, directed_rows[n].h,
                         directed_rows[n].empty, directed_rows[n].last,
                         directed_rows[n].typed, directed_rows[n].want);
            end
        end

        // random phases, each with a fresh set of registers
        for (phase = 0; phase < PHASES; phase++) begin
            drain_pipe();
            if (phase % 10 == 0) begin
                // widest area, widest gaps, largest pad
                settings = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                             16'd1023, 16'd1023, 16'd0, 16'd4095};
            end else if (phase % 10 == 5) begin
                // single-point area: nearly every box wraps
                settings[0] = CFG_W'($urandom_range(0, 400));
                settings[1] = CFG_W'($urandom_range(0, 400));
                settings[2] = settings[0];
                settings[3] = settings[1];
                settings[4] = '0;
                settings[5] = '0;
                settings[7] = '0;
            end else if (phase % 5 == 4) begin
                // anything goes, inverted areas and junk upper bits included
                for (k = 0; k < 8; k++) settings[k] = CFG_W'($urandom);
            end else begin
                settings[0] = CFG_W'($urandom_range(0, 2000) - 1000);
                settings[1] = CFG_W'($urandom_range(0, 2000) - 1000);
                settings[2] = settings[0] + CFG_W'($urandom_range(50, 3000));
                settings[3] = settings[1] + CFG_W'($urandom_range(50, 3000));
                settings[4] = CFG_W'($urandom_range(0, 40));
                settings[5] = CFG_W'($urandom_range(0, 40));
                settings[7] = CFG_W'($urandom_range(0, 4095));
            end
            settings[6] = CFG_W'($urandom_range(0, 3));
            for (k = 0; k < 8; k++) write_reg(t_reg_idx'(k), settings[k]);

            // ask the receiver for its long hold-off while items keep coming
            if (phase == 3) hold_req = 1'b1;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 15) begin
                    w = $urandom_range(0, 400);
                    h = $urandom_range(0, 400);
                end else if (pick < 18) begin
                    w = $urandom_range(0, 32767);
                    h = $urandom_range(0, 32767);
                end else begin
                    w = (pick == 18) ? 32767 : 0;
                    h = $urandom_range(0, 1) ? 32767 : 0;
                end
                send_box(w, h, $urandom_range(0, 9) == 0, $urandom_range(0, 11) == 0,
                         1'b0, NO_RESULT);
            end
        end

        // wait for the last results, then a little longer for strays
        i_valid <= 1'b0;
        while (placement_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
        if (errors == 0) begin
            $display("flow_layout_wrap_placer test passed");
        end else begin
            $display("flow_layout_wrap_placer test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: segments of no stall, random stall, periodic stall and heavy
    // stall, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int  seg_kind, seg_len, n;
        bit  hold_done;
        bit  stall_now;
        hold_done = 1'b0;
        forever begin
            seg_kind = $urandom_range(0, 3);
            seg_len  = $urandom_range(20, 150);
            for (n = 0; n < seg_len; n++) begin
                if (hold_req && !hold_done) begin
                    // hold off long enough for the pipe to fill and stall
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_done = 1'b1;
                end
                case (seg_kind)
                    0:       stall_now = 1'b0;
                    1:       stall_now = ($urandom_range(0, 99) < 30);
                    2:       stall_now = ((n % 4) == 3);
                    default: stall_now = ($urandom_range(0, 99) < 75);
                endcase
                i_stall <= stall_now;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        placement_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (placement_q.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
            end else begin
                want = placement_q.pop_front();
                compare_field("pos_x", $signed(want.pos_x), o_pos_x);
                compare_field("pos_y", $signed(want.pos_y), o_pos_y);
                compare_field("placed", want.placed, o_placed);
                compare_field("wrapped", want.wrapped, o_wrapped);
                compare_field("extent_w", want.extent_w, o_extent_w);
                compare_field("extent_h", want.extent_h, o_extent_h);
                compare_field("end_of_list", want.end_of_list, o_end_of_list);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which neither side moves an item
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("flow_layout_wrap_placer test failed");
        $finish;
    end

endmodule
